### rtl/core/rse_pkg.sv
// Package: tables and constants for the reciprocal square root estimate unit
package rse_pkg;

   localparam int DataWidth = 64;
   localparam int LzcWidth = 6;

   localparam logic [63:0] DefaultQnan = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] PosInf = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] QuietBit = 64'h0008_0000_0000_0000;

   typedef enum logic [1:0] {
      KIND_NORMAL = 2'd0,
      KIND_FIXED = 2'd1
   } kind_type;

   function automatic logic [25:0] base_lookup(input logic [4:0] idx);
      logic [25:0] r;
      case (idx)
         5'd0: r = 26'h3ffa000;  5'd1: r = 26'h3c29000;
         5'd2: r = 26'h38aa000;  5'd3: r = 26'h3572000;
         5'd4: r = 26'h3279000;  5'd5: r = 26'h2fb7000;
         5'd6: r = 26'h2d26000;  5'd7: r = 26'h2ac0000;
         5'd8: r = 26'h2881000;  5'd9: r = 26'h2665000;
         5'd10: r = 26'h2468000; 5'd11: r = 26'h2287000;
         5'd12: r = 26'h20c1000; 5'd13: r = 26'h1f12000;
         5'd14: r = 26'h1d79000; 5'd15: r = 26'h1bf4000;
         5'd16: r = 26'h1a7e800; 5'd17: r = 26'h17cb800;
         5'd18: r = 26'h1552800; 5'd19: r = 26'h130c000;
         5'd20: r = 26'h10f2000; 5'd21: r = 26'h0eff000;
         5'd22: r = 26'h0d2e000; 5'd23: r = 26'h0b7c000;
         5'd24: r = 26'h09e5000; 5'd25: r = 26'h0867000;
         5'd26: r = 26'h06ff000; 5'd27: r = 26'h05ab800;
         5'd28: r = 26'h046a000; 5'd29: r = 26'h0339800;
         5'd30: r = 26'h0218800; 5'd31: r = 26'h0105800;
         default: r = 26'h0;
      endcase
      return r;
   endfunction

   function automatic logic [10:0] slope_lookup(input logic [4:0] idx);
      logic [10:0] r;
      case (idx)
         5'd0: r = 11'h7a4;  5'd1: r = 11'h700;  5'd2: r = 11'h670;  5'd3: r = 11'h5f2;
         5'd4: r = 11'h584;  5'd5: r = 11'h524;  5'd6: r = 11'h4cc;  5'd7: r = 11'h47e;
         5'd8: r = 11'h43a;  5'd9: r = 11'h3fa;  5'd10: r = 11'h3c2; 5'd11: r = 11'h38e;
         5'd12: r = 11'h35e; 5'd13: r = 11'h332; 5'd14: r = 11'h30a; 5'd15: r = 11'h2e6;
         5'd16: r = 11'h568; 5'd17: r = 11'h4f3; 5'd18: r = 11'h48d; 5'd19: r = 11'h435;
         5'd20: r = 11'h3e7; 5'd21: r = 11'h3a2; 5'd22: r = 11'h365; 5'd23: r = 11'h32e;
         5'd24: r = 11'h2fc; 5'd25: r = 11'h2d0; 5'd26: r = 11'h2a8; 5'd27: r = 11'h283;
         5'd28: r = 11'h261; 5'd29: r = 11'h243; 5'd30: r = 11'h226; 5'd31: r = 11'h20b;
         default: r = 11'h0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/reciprocal_sqrt_estimate_unit.sv
// Top level: pipelined table-based reciprocal square root estimate
// An accepted beat passes the stage 1, 2 and 3 registers and the output register.
// Throughput: one beat per cycle while not stalled by rsp_tready; stages are
// classify/leading-zero count, normalize, table lookup and multiply, subtract and pack.
// The pipeline advances whenever the output stage is empty or being drained.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
module reciprocal_sqrt_estimate_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rse_pkg::DataWidth-1:0] req_tdata,  // [63:0] operand_bits
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rse_pkg::DataWidth-1:0] rsp_tdata   // [63:0] estimate_bits
);

   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // stage 1: classify, leading-zero count
   logic v1_ff, v1_in;
   rse_pkg::kind_type k1_ff, k1_in;
   logic [63:0] fix1_ff, fix1_in;
   logic [51:0] frac1_ff;
   logic [10:0] e1_ff;
   logic [rse_pkg::LzcWidth-1:0] lz1_ff, lz1_in;

   logic [51:0] frac_a;
   logic [10:0] e_a;
   logic sgn_a;
   always_comb begin
      frac_a = req_tdata[51:0];
      e_a = req_tdata[62:52];
      sgn_a = req_tdata[63];
      v1_in = req_tvalid;
      k1_in = rse_pkg::KIND_FIXED;
      fix1_in = rse_pkg::DefaultQnan;
      if (e_a == 11'd0 && frac_a == 52'd0) begin
         fix1_in = {sgn_a, rse_pkg::PosInf[62:0]};
      end else if (e_a == 11'h7FF) begin
         if (frac_a == 52'd0) fix1_in = sgn_a ? rse_pkg::DefaultQnan : 64'd0;
         else fix1_in = req_tdata | rse_pkg::QuietBit;
      end else if (!sgn_a) begin
         k1_in = rse_pkg::KIND_NORMAL;
      end
      lz1_in = '0;
      for (int i = 0; i < 52; i++) begin
         if (frac_a[i]) lz1_in = rse_pkg::LzcWidth'(51 - i);
      end
   end

   // stage 2: normalize, exponent
   logic v2_ff;
   rse_pkg::kind_type k2_ff;
   logic [63:0] fix2_ff;
   logic [14:0] top2_ff, top2_in;
   logic [10:0] ne2_ff, ne2_in;
   logic even2_ff, even2_in;

   logic [51:0] sh_b;
   logic signed [12:0] ee_b;
   logic [12:0] n_b;
   always_comb begin
      if (e1_ff == 11'd0) begin
         sh_b = frac1_ff << (lz1_ff + 1'b1);
         ee_b = 13'sd0 - $signed({7'd0, lz1_ff});
      end else begin
         sh_b = frac1_ff;
         ee_b = $signed({2'b0, e1_ff});
      end
      top2_in = sh_b[51:37];
      even2_in = !ee_b[0];
      n_b = 13'(13'sd3068 - ee_b);
      ne2_in = n_b[11:1];
   end

   // stage 3: lookup and multiply
   logic v3_ff;
   rse_pkg::kind_type k3_ff;
   logic [63:0] fix3_ff;
   logic [10:0] ne3_ff;
   logic [25:0] base3_ff;
   logic [21:0] prod3_ff, prod3_in;
   logic [4:0] idx_c;
   always_comb begin
      idx_c = {even2_ff, top2_ff[14:11]};
      prod3_in = 22'(rse_pkg::slope_lookup(idx_c) * top2_ff[10:0]);
   end

   // stage 4: subtract and pack
   logic [63:0] out_in, out_ff;
   logic [25:0] val_d;
   always_comb begin
      val_d = base3_ff - {4'd0, prod3_ff};
      out_in = (k3_ff == rse_pkg::KIND_FIXED) ? fix3_ff : {1'b0, ne3_ff, val_d, 26'd0};
   end

   logic vo_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in; v2_ff <= v1_ff; v3_ff <= v2_ff; vo_ff <= v3_ff;
      end
      if (adv) begin
         k1_ff <= k1_in; fix1_ff <= fix1_in; frac1_ff <= frac_a; e1_ff <= e_a;
         lz1_ff <= lz1_in;
         k2_ff <= k1_ff; fix2_ff <= fix1_ff; top2_ff <= top2_in; ne2_ff <= ne2_in;
         even2_ff <= even2_in;
         k3_ff <= k2_ff; fix3_ff <= fix2_ff; ne3_ff <= ne2_ff;
         base3_ff <= rse_pkg::base_lookup(idx_c); prod3_ff <= prod3_in;
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata = out_ff;

endmodule
